[src/fwes_pkg.sv]
// Shared types and constants for the fixed-width entry sorter.
// Holds the beat structs and the sequencer state encoding; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fwes_pkg;

  localparam int DATA_W = 32;

  typedef struct packed {
    logic [DATA_W-1:0] entry_value;
    logic              last_in;
  } in_beat_t;

  typedef struct packed {
    logic [DATA_W-1:0] sorted_value;
    logic              last_out;
    logic              overflow;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FIRST,
    ST_PRIME,
    ST_PASS,
    ST_TAIL,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } seq_state_t;

endpackage
`default_nettype wire

[src/fwes_mem.sv]
// Entry store: one write port, one read port with registered read data.
// Depends on fwes_pkg for the data width.
`timescale 1ns / 1ps
`default_nettype none
module fwes_mem #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [ADDR_W-1:0]          waddr,
  input  wire logic [fwes_pkg::DATA_W-1:0] wdata,
  input  wire logic                       re,
  input  wire logic [ADDR_W-1:0]          raddr,
  output logic      [fwes_pkg::DATA_W-1:0] rdata
);

  logic [fwes_pkg::DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[src/fixed_width_entry_sorter.sv]
// Top level of the fixed-width entry sorter: load sequencer, in-memory
// bubble-pass sort and emit stage. Depends on fwes_pkg and fwes_mem.
//
// Usage:
//   src channel: one entry per beat (entry_value, last_in). Entries are
//   written into the store at one per cycle; src_stall is high whenever the
//   block is sorting or emitting.
//   When a beat with last_in arrives, the stored set is sorted in place by
//   repeated passes over the store. Each pass carries the larger value
//   upward through the single read and single write port; passes stop
//   early when one makes no exchange.
//   dst channel: the sorted set, ascending; each entry is read from the store
//   before its beat is offered, and the next read waits until the beat is
//   taken; last_out marks the final entry and overflow is set on every beat
//   of a set that lost entries beyond MAX_ENTRIES. A stalled beat is held
//   unchanged until taken. After the last beat the block returns to loading.
//   Reset clears the entry count, the overflow flag and the sequencer; the
//   store contents need no clearing since only loaded entries are read.
`timescale 1ns / 1ps
`default_nettype none
module fixed_width_entry_sorter #(
  parameter int MAX_ENTRIES = 64,
  parameter int ENTRY_BYTES = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                src_valid,
  output logic                     src_stall,
  input  wire fwes_pkg::in_beat_t  src_item,
  output logic                     dst_valid,
  input  wire logic                dst_stall,
  output fwes_pkg::out_beat_t      dst_item
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int MW = (ENTRY_BYTES >= 4) ? fwes_pkg::DATA_W : ENTRY_BYTES * 8;
  localparam logic [fwes_pkg::DATA_W-1:0] MASK =
    fwes_pkg::DATA_W'((64'(1) << MW) - 64'(1));

  fwes_pkg::seq_state_t state, state_next;

  logic [CW-1:0] count;
  logic          dropped;
  logic [AW-1:0] top;
  logic [AW-1:0] idx;
  logic          swapped;
  logic [fwes_pkg::DATA_W-1:0] carry;

  logic                        we;
  logic [AW-1:0]               waddr;
  logic [fwes_pkg::DATA_W-1:0] wdata;
  logic                        re;
  logic [AW-1:0]               raddr;
  logic [fwes_pkg::DATA_W-1:0] rdata;

  logic src_acc, dst_acc, room, is_last, carry_gt;
  logic [CW-1:0] count_after;

  assign src_acc  = src_valid && !src_stall;
  assign dst_acc  = dst_valid && !dst_stall;
  assign room     = count < CW'(MAX_ENTRIES);
  assign count_after = room ? count + CW'(1) : count;
  assign is_last  = ({{(CW-AW){1'b0}}, idx} + CW'(1)) == count;
  assign carry_gt = carry > rdata;

  fwes_mem #(.DEPTH(MAX_ENTRIES), .ADDR_W(AW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      fwes_pkg::ST_LOAD: begin
        if (src_acc && src_item.last_in) begin
          state_next = (count_after < CW'(2)) ? fwes_pkg::ST_EMIT_RD : fwes_pkg::ST_FIRST;
        end
      end
      fwes_pkg::ST_FIRST: state_next = fwes_pkg::ST_PRIME;
      fwes_pkg::ST_PRIME: state_next = fwes_pkg::ST_PASS;
      fwes_pkg::ST_PASS: begin
        if (idx == top) begin
          state_next = fwes_pkg::ST_TAIL;
        end
      end
      fwes_pkg::ST_TAIL: begin
        state_next = (!swapped || top == AW'(1)) ? fwes_pkg::ST_EMIT_RD : fwes_pkg::ST_FIRST;
      end
      fwes_pkg::ST_EMIT_RD: state_next = fwes_pkg::ST_EMIT_OUT;
      fwes_pkg::ST_EMIT_OUT: begin
        if (dst_acc) begin
          state_next = is_last ? fwes_pkg::ST_LOAD : fwes_pkg::ST_EMIT_RD;
        end
      end
      default: state_next = fwes_pkg::ST_LOAD;
    endcase
  end

  // Memory port and handshake outputs
  always_comb begin
    we    = 1'b0;
    waddr = count[AW-1:0];
    wdata = src_item.entry_value & MASK;
    re    = 1'b0;
    raddr = idx;
    src_stall = 1'b1;
    dst_valid = 1'b0;
    case (state)
      fwes_pkg::ST_LOAD: begin
        src_stall = 1'b0;
        we = src_acc && room;
      end
      fwes_pkg::ST_FIRST: begin
        re    = 1'b1;
        raddr = '0;
      end
      fwes_pkg::ST_PRIME: begin
        re    = 1'b1;
        raddr = AW'(1);
      end
      fwes_pkg::ST_PASS: begin
        we    = 1'b1;
        waddr = idx - AW'(1);
        wdata = carry_gt ? rdata : carry;
        re    = idx != top;
        raddr = idx + AW'(1);
      end
      fwes_pkg::ST_TAIL: begin
        we    = 1'b1;
        waddr = top;
        wdata = carry;
      end
      fwes_pkg::ST_EMIT_RD: begin
        re    = 1'b1;
        raddr = idx;
      end
      fwes_pkg::ST_EMIT_OUT: dst_valid = 1'b1;
      default: ;
    endcase
  end

  assign dst_item.sorted_value = rdata;
  assign dst_item.last_out     = is_last;
  assign dst_item.overflow     = dropped;

  // Advance the sequencer and its counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= fwes_pkg::ST_LOAD;
      count   <= '0;
      dropped <= 1'b0;
      idx     <= '0;
      top     <= '0;
      swapped <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        fwes_pkg::ST_LOAD: begin
          if (src_acc) begin
            count <= count_after;
            if (!room) begin
              dropped <= 1'b1;
            end
            idx <= '0;
            top <= AW'(count_after - CW'(1));
          end
        end
        fwes_pkg::ST_FIRST: swapped <= 1'b0;
        fwes_pkg::ST_PRIME: idx <= AW'(1);
        fwes_pkg::ST_PASS: begin
          if (carry_gt) begin
            swapped <= 1'b1;
          end
          if (idx != top) begin
            idx <= idx + AW'(1);
          end
        end
        fwes_pkg::ST_TAIL: begin
          top <= top - AW'(1);
          idx <= '0;
        end
        fwes_pkg::ST_EMIT_OUT: begin
          if (dst_acc) begin
            if (is_last) begin
              count   <= '0;
              dropped <= 1'b0;
              idx     <= '0;
            end else begin
              idx <= idx + AW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Carry the larger value up through the pass
  always_ff @(posedge clk) begin
    if (state == fwes_pkg::ST_PRIME) begin
      carry <= rdata;
    end else if (state == fwes_pkg::ST_PASS && !carry_gt) begin
      carry <= rdata;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ENTRIES))
    else $error("entry count beyond capacity");

  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    src_acc && src_item.last_in |=> src_stall)
    else $error("input taken after final entry");

  a_done_reloads: assert property (@(posedge clk) disable iff (rst)
    dst_acc && dst_item.last_out |=> !src_stall && count == '0)
    else $error("not back to loading after final beat");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(dst_valid && !src_stall))
    else $error("emitting while loading");

endmodule
`default_nettype wire
